@@ hw/rtl/rsw_pkg.sv @@
// shared types and constants for the running statistics unit
package rsw_pkg;

	localparam int DATA_W = 64;
	localparam int HALF_W = 32;
	localparam int STD_W  = 48;
	localparam int CNT_W  = 6;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_END   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_UPDATE,
		ST_DIV_MEAN,
		ST_DIFF,
		ST_MUL,
		ST_DIV_VAR,
		ST_SQRT,
		ST_FINISH
	} state_t;

	// multiply sequence over 32-bit halves, low 64 bits of the product only
	localparam logic [CNT_W-1:0] MUL_P0   = CNT_W'(0);
	localparam logic [CNT_W-1:0] MUL_P1   = CNT_W'(1);
	localparam logic [CNT_W-1:0] MUL_P2   = CNT_W'(2);
	localparam logic [CNT_W-1:0] MUL_P3   = CNT_W'(3);
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(4);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DATA_W - 1);

endpackage

@@ hw/rtl/running_stats_welford_unit.sv @@
// interval timer with running count, mean, min, max and standard deviation
// an end item that adds a sample runs decode, update, two 64-step radix-2 divides, a 5-step
// multiply and a 32+STD_FRAC_BITS step root; a count that wraps to zero skips divides and root
// start, clear, no-op and misordered items skip to the result; one item at a time, the next
// taken the cycle after the result loads, later while a stalled result holds the output register
// arst_n low clears all statistics (min to all ones), closes the interval and idles the block
module running_stats_welford_unit #(
	parameter int TIME_BITS     = 64,
	parameter int STD_FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                operation,
	input  logic [rsw_pkg::DATA_W-1:0] time_now,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [rsw_pkg::DATA_W-1:0] sample_count,
	output logic [rsw_pkg::DATA_W-1:0] min_sample,
	output logic [rsw_pkg::DATA_W-1:0] max_sample,
	output logic [rsw_pkg::DATA_W-1:0] mean_sample,
	output logic [rsw_pkg::STD_W-1:0]  std_dev,
	output logic                      interval_open,
	output logic                      sequence_error
);

	localparam int DW     = rsw_pkg::DATA_W;
	localparam int ROOT_W = rsw_pkg::HALF_W + STD_FRAC_BITS;
	localparam int RAD_W  = DW + 2 * STD_FRAC_BITS;
	localparam logic [rsw_pkg::CNT_W-1:0] ROOT_LAST = rsw_pkg::CNT_W'(ROOT_W - 1);

	rsw_pkg::state_t state_q, state_d;
	rsw_pkg::op_t    op_q;

	logic [TIME_BITS-1:0] now_q, start_q, elapsed;
	logic                 open_q, err_q;
	logic [DW-1:0]        count_q, sum_q, mean_q, sumsq_q, min_q, max_q;
	logic [rsw_pkg::STD_W-1:0] std_q;

	logic [DW-1:0]        sample_q, da_q, db_q, rem_q, quo_q, den_q, acc_q, prod_s1;
	logic [RAD_W-1:0]     rad_q;
	logic [ROOT_W-1:0]    root_q, root_nx;
	logic [rsw_pkg::CNT_W-1:0] step_q;

	logic [DW+1:0]        sub_a, sub_b;
	logic [DW+2:0]        sub_full;
	logic                 sub_ge;
	logic [DW-1:0]        rem_nx, quo_nx;
	logic [DW-1:0]        cnt_nx, sum_nx, sumsq_nx, mul_p;
	logic [rsw_pkg::HALF_W-1:0] mul_a, mul_b;
	logic                 div_last, out_load;

	logic                 out_valid_q, out_open_q, out_err_q;
	logic [DW-1:0]        out_count_q, out_min_q, out_max_q, out_mean_q;
	logic [rsw_pkg::STD_W-1:0] out_std_q;

	assign elapsed  = now_q - start_q;
	assign cnt_nx   = count_q + DW'(1);
	assign sum_nx   = sum_q + sample_q;
	assign sumsq_nx = sumsq_q + acc_q;
	assign div_last = (step_q == rsw_pkg::DIV_LAST);

	// shared compare and subtract for the divide and square root loops
	always_comb begin
		sub_a = '0;
		sub_b = '0;
		case (state_q)
			rsw_pkg::ST_DIV_MEAN, rsw_pkg::ST_DIV_VAR: begin
				sub_a = {1'b0, rem_q, quo_q[DW-1]};
				sub_b = {2'b00, den_q};
			end
			rsw_pkg::ST_SQRT: begin
				sub_a = {rem_q, rad_q[RAD_W-1 -: 2]};
				sub_b = (DW + 2)'({root_q, 2'b01});
			end
			default: ;
		endcase
		sub_full = {1'b0, sub_a} - {1'b0, sub_b};
	end

	assign sub_ge  = !sub_full[DW+2];
	assign rem_nx  = sub_ge ? sub_full[DW-1:0] : sub_a[DW-1:0];
	assign quo_nx  = {quo_q[DW-2:0], sub_ge};
	assign root_nx = {root_q[ROOT_W-2:0], sub_ge};

	// 32x32 multiplier walked over the halves of the two differences
	assign mul_a = step_q[1] ? da_q[DW-1:rsw_pkg::HALF_W] : da_q[rsw_pkg::HALF_W-1:0];
	assign mul_b = (step_q == rsw_pkg::MUL_P1) ? db_q[DW-1:rsw_pkg::HALF_W]
	                                           : db_q[rsw_pkg::HALF_W-1:0];
	assign mul_p = {{rsw_pkg::HALF_W{1'b0}}, mul_a} * {{rsw_pkg::HALF_W{1'b0}}, mul_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		case (state_q)
			rsw_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = rsw_pkg::ST_DECODE;
				end
			end
			rsw_pkg::ST_DECODE: begin
				if (op_q == rsw_pkg::OP_END && open_q) begin
					state_d = rsw_pkg::ST_UPDATE;
				end else begin
					state_d = rsw_pkg::ST_FINISH;
				end
			end
			rsw_pkg::ST_UPDATE: begin
				state_d = (cnt_nx != '0) ? rsw_pkg::ST_DIV_MEAN : rsw_pkg::ST_DIFF;
			end
			rsw_pkg::ST_DIV_MEAN: begin
				if (div_last) begin
					state_d = rsw_pkg::ST_DIFF;
				end
			end
			rsw_pkg::ST_DIFF: begin
				state_d = rsw_pkg::ST_MUL;
			end
			rsw_pkg::ST_MUL: begin
				if (step_q == rsw_pkg::MUL_LAST) begin
					state_d = (count_q != '0) ? rsw_pkg::ST_DIV_VAR : rsw_pkg::ST_FINISH;
				end
			end
			rsw_pkg::ST_DIV_VAR: begin
				if (div_last) begin
					state_d = rsw_pkg::ST_SQRT;
				end
			end
			rsw_pkg::ST_SQRT: begin
				if (step_q == ROOT_LAST) begin
					state_d = rsw_pkg::ST_FINISH;
				end
			end
			rsw_pkg::ST_FINISH: begin
				// result register frees up when empty or taken this cycle
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = rsw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rsw_pkg::ST_IDLE;
			end
		endcase
	end

	// architectural statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= '0;
			open_q      <= 1'b0;
			count_q     <= '0;
			sum_q       <= '0;
			mean_q      <= '0;
			sumsq_q     <= '0;
			min_q       <= '1;
			max_q       <= '0;
			std_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				rsw_pkg::ST_DECODE: begin
					case (op_q)
						rsw_pkg::OP_START: begin
							if (!open_q) begin
								start_q <= now_q;
								open_q  <= 1'b1;
							end
						end
						rsw_pkg::OP_END: begin
							open_q <= 1'b0;
						end
						rsw_pkg::OP_CLEAR: begin
							count_q <= '0;
							sum_q   <= '0;
							mean_q  <= '0;
							sumsq_q <= '0;
							min_q   <= '1;
							max_q   <= '0;
							std_q   <= '0;
						end
						default: ;
					endcase
				end
				rsw_pkg::ST_UPDATE: begin
					count_q <= cnt_nx;
					sum_q   <= sum_nx;
					if (sample_q < min_q) begin
						min_q <= sample_q;
					end
					if (sample_q > max_q) begin
						max_q <= sample_q;
					end
					// count wrapped to zero
					if (cnt_nx == '0) begin
						mean_q <= '0;
					end
				end
				rsw_pkg::ST_DIV_MEAN: begin
					if (div_last) begin
						mean_q <= quo_nx;
					end
				end
				rsw_pkg::ST_MUL: begin
					if (step_q == rsw_pkg::MUL_LAST) begin
						sumsq_q <= sumsq_nx;
						if (count_q == '0) begin
							std_q <= '0;
						end
					end
				end
				rsw_pkg::ST_SQRT: begin
					if (step_q == ROOT_LAST) begin
						std_q <= rsw_pkg::STD_W'(root_nx);
					end
				end
				default: ;
			endcase
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		if (state_q == rsw_pkg::ST_IDLE && in_valid) begin
			op_q  <= rsw_pkg::op_t'(operation);
			now_q <= time_now[TIME_BITS-1:0];
		end
		case (state_q)
			rsw_pkg::ST_DECODE: begin
				sample_q <= DW'(elapsed);
				err_q    <= (op_q == rsw_pkg::OP_START && open_q) ||
				            (op_q == rsw_pkg::OP_END && !open_q);
			end
			rsw_pkg::ST_UPDATE: begin
				da_q   <= sample_q - mean_q;
				rem_q  <= '0;
				quo_q  <= sum_nx;
				den_q  <= cnt_nx;
				step_q <= '0;
			end
			rsw_pkg::ST_DIV_MEAN: begin
				rem_q  <= rem_nx;
				quo_q  <= quo_nx;
				step_q <= step_q + rsw_pkg::CNT_W'(1);
			end
			rsw_pkg::ST_DIFF: begin
				db_q   <= sample_q - mean_q;
				step_q <= '0;
			end
			rsw_pkg::ST_MUL: begin
				prod_s1 <= mul_p;
				step_q  <= step_q + rsw_pkg::CNT_W'(1);
				case (step_q)
					rsw_pkg::MUL_P1: begin
						acc_q <= prod_s1;
					end
					rsw_pkg::MUL_P2, rsw_pkg::MUL_P3: begin
						acc_q <= acc_q + {prod_s1[rsw_pkg::HALF_W-1:0],
						                  {rsw_pkg::HALF_W{1'b0}}};
					end
					default: ;
				endcase
				if (step_q == rsw_pkg::MUL_LAST) begin
					rem_q  <= '0;
					quo_q  <= sumsq_nx;
					den_q  <= count_q;
					step_q <= '0;
				end
			end
			rsw_pkg::ST_DIV_VAR: begin
				rem_q  <= rem_nx;
				quo_q  <= quo_nx;
				step_q <= step_q + rsw_pkg::CNT_W'(1);
				if (div_last) begin
					rad_q  <= RAD_W'(quo_nx) << (2 * STD_FRAC_BITS);
					rem_q  <= '0;
					root_q <= '0;
					step_q <= '0;
				end
			end
			rsw_pkg::ST_SQRT: begin
				rem_q  <= rem_nx;
				root_q <= root_nx;
				rad_q  <= rad_q << 2;
				step_q <= step_q + rsw_pkg::CNT_W'(1);
			end
			rsw_pkg::ST_FINISH: begin
				if (out_load) begin
					out_count_q <= count_q;
					out_min_q   <= min_q;
					out_max_q   <= max_q;
					out_mean_q  <= mean_q;
					out_std_q   <= std_q;
					out_open_q  <= open_q;
					out_err_q   <= err_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign sample_count   = out_count_q;
	assign min_sample     = out_min_q;
	assign max_sample     = out_max_q;
	assign mean_sample    = out_mean_q;
	assign std_dev        = out_std_q;
	assign interval_open  = out_open_q;
	assign sequence_error = out_err_q;

endmodule

@@ hw/rtl/rsw_checker.sv @@
// port-level checks for the running statistics unit, bound to the top level
module rsw_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [rsw_pkg::DATA_W-1:0] sample_count,
	input logic [rsw_pkg::DATA_W-1:0] min_sample,
	input logic [rsw_pkg::DATA_W-1:0] max_sample,
	input logic [rsw_pkg::DATA_W-1:0] mean_sample,
	input logic [rsw_pkg::STD_W-1:0]  std_dev
);

	// an accepted item keeps the block busy for at least the next cycle
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on the cycle after a transfer");

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// with no samples the mean and deviation read zero
	a_empty_stats: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_count == '0 |-> std_dev == '0 && mean_sample == '0)
		else $error("nonzero mean or deviation with zero count");

	// any sample since the last clear keeps min at or below max
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_count != '0 |-> min_sample <= max_sample)
		else $error("min above max with samples present");

endmodule

bind running_stats_welford_unit rsw_checker u_rsw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.sample_count (sample_count),
	.min_sample   (min_sample),
	.max_sample   (max_sample),
	.mean_sample  (mean_sample),
	.std_dev      (std_dev)
);

@@ sim/running_stats_welford_unit_test.sv @@
// self-checking testbench for the interval timer with running statistics
`timescale 1ns / 1ps

module running_stats_welford_unit_test;

	localparam int DATA_W      = rsw_pkg::DATA_W;
	localparam int STD_W       = rsw_pkg::STD_W;
	localparam int TIME_BITS   = 64;
	localparam int FRAC_BITS   = 16;
	localparam int ITEM_TARGET = 1650;
	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 400;
	localparam logic [DATA_W-1:0] ALL_ONES  = '1;
	localparam logic [DATA_W-1:0] TIME_MASK = ALL_ONES >> (DATA_W - TIME_BITS);

	typedef struct {
		logic [DATA_W-1:0] count;
		logic [DATA_W-1:0] smallest;
		logic [DATA_W-1:0] largest;
		logic [DATA_W-1:0] mean;
		logic [STD_W-1:0]  spread;
		logic              is_open;
		logic              misordered;
	} interval_stats_t;

	class interval_stats_board;
		logic [DATA_W-1:0] start_stamp;
		logic [DATA_W-1:0] n;
		logic [DATA_W-1:0] total;
		logic [DATA_W-1:0] avg;
		logic [DATA_W-1:0] sq_acc;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
		bit running;
		interval_stats_t expected_q[$];
		int mismatches;
		int checked;
		int samples_added;
		int misordered_seen;
		int op_seen[4];

		function new();
			wipe();
			running = 0;
			start_stamp = '0;
		endfunction

		function void wipe();
			n = '0;
			total = '0;
			avg = '0;
			sq_acc = '0;
			lo = ALL_ONES;
			hi = '0;
		endfunction

		// floor(sqrt(v) * 2^FRAC_BITS), one result bit per step
		function logic [STD_W-1:0] fixed_root(logic [DATA_W-1:0] v);
			logic [127:0] target;
			logic [127:0] trial_sq;
			logic [STD_W-1:0] r;
			logic [STD_W-1:0] trial;
			target = {64'd0, v} << (2 * FRAC_BITS);
			r = '0;
			for (int b = 31 + FRAC_BITS; b >= 0; b--) begin
				trial = r | (STD_W'(1) << b);
				trial_sq = 128'(trial) * 128'(trial);
				if (trial_sq <= target) begin
					r = trial;
				end
			end
			return r;
		endfunction

		function void note_event(rsw_pkg::op_t op, logic [DATA_W-1:0] t);
			interval_stats_t e;
			logic [DATA_W-1:0] now;
			logic [DATA_W-1:0] s;
			logic [DATA_W-1:0] prev_avg;
			bit bad;
			now = t & TIME_MASK;
			bad = 0;
			op_seen[op]++;
			case (op)
				rsw_pkg::OP_START: begin
					if (running) begin
						bad = 1;
					end else begin
						start_stamp = now;
						running = 1;
					end
				end
				rsw_pkg::OP_END: begin
					if (!running) begin
						bad = 1;
					end else begin
						s = (now - start_stamp) & TIME_MASK;
						prev_avg = avg;
						n = n + 1;
						total = total + s;
						avg = (n != 0) ? total / n : '0;
						// welford update, wraps at 64 bits
						sq_acc = sq_acc + (s - prev_avg) * (s - avg);
						if (s < lo) begin
							lo = s;
						end
						if (s > hi) begin
							hi = s;
						end
						running = 0;
						samples_added++;
					end
				end
				rsw_pkg::OP_CLEAR: begin
					wipe();
				end
				default: begin
				end
			endcase
			if (bad) begin
				misordered_seen++;
			end
			e.count = n;
			e.smallest = lo;
			e.largest = hi;
			e.mean = avg;
			e.spread = (n != 0) ? fixed_root(sq_acc / n) : '0;
			e.is_open = running;
			e.misordered = bad;
			expected_q.push_back(e);
		endfunction

		function void check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] seen);
			if (seen !== want) begin
				$error("%s: expected %0h, got %0h", name, want, seen);
				mismatches++;
			end
		endfunction

		function void check_stats(interval_stats_t got);
			interval_stats_t e;
			if (expected_q.size() == 0) begin
				$error("result transfer with no item outstanding");
				mismatches++;
				return;
			end
			e = expected_q.pop_front();
			checked++;
			check_field("sample_count", e.count, got.count);
			check_field("min_sample", e.smallest, got.smallest);
			check_field("max_sample", e.largest, got.largest);
			check_field("mean_sample", e.mean, got.mean);
			check_field("std_dev", DATA_W'(e.spread), DATA_W'(got.spread));
			check_field("interval_open", DATA_W'(e.is_open), DATA_W'(got.is_open));
			check_field("sequence_error", DATA_W'(e.misordered), DATA_W'(got.misordered));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        operation = rsw_pkg::OP_NOP;
	logic [DATA_W-1:0] time_now = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [DATA_W-1:0] sample_count;
	logic [DATA_W-1:0] min_sample;
	logic [DATA_W-1:0] max_sample;
	logic [DATA_W-1:0] mean_sample;
	logic [STD_W-1:0]  std_dev;
	logic              interval_open;
	logic              sequence_error;

	interval_stats_board board = new();
	bit quiet_phase = 0;
	int items_sent = 0;

	running_stats_welford_unit #(
		.TIME_BITS(TIME_BITS),
		.STD_FRAC_BITS(FRAC_BITS)
	) DUT (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 65) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(15, 80);
	endfunction

	function automatic logic [DATA_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [DATA_W-1:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return DATA_W'($urandom_range(0, 5000));
		end
		if (r < 75) begin
			return DATA_W'($urandom);
		end
		if (r < 90) begin
			return rand64();
		end
		return ALL_ONES - DATA_W'($urandom_range(0, 1000));
	endfunction

	task automatic send_event(rsw_pkg::op_t op, logic [DATA_W-1:0] t);
		int gap;
		gap = pick_pause();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		time_now <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_event(op, t);
		items_sent++;
	endtask

	// hold the sender until every outstanding result has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.expected_q.size() != 0) @(posedge clk);
	endtask

	// result side back-pressure
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (out_stall) begin
				out_stall <= 1'b0;
				hold = $urandom_range(0, 8);
			end else begin
				hold = pick_pause();
				if (hold > 0) begin
					out_stall <= 1'b1;
					hold--;
				end
			end
		end
	end

	always @(posedge clk) begin
		interval_stats_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.count = sample_count;
			got.smallest = min_sample;
			got.largest = max_sample;
			got.mean = mean_sample;
			got.spread = std_dev;
			got.is_open = interval_open;
			got.misordered = sequence_error;
			board.check_stats(got);
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("no transfer for %0d cycles", IDLE_LIMIT);
		$display("running_stats_welford_unit_test: FAIL");
		$finish;
	end

	initial begin
		int r;
		int next_drain;
		logic [DATA_W-1:0] stamp;
		logic [DATA_W-1:0] wall;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset state, misordered events, wrap, clear while open
		send_event(rsw_pkg::OP_NOP, '0);
		send_event(rsw_pkg::OP_END, ALL_ONES);
		send_event(rsw_pkg::OP_START, '0);
		send_event(rsw_pkg::OP_START, 64'd123);
		send_event(rsw_pkg::OP_END, '0);
		send_event(rsw_pkg::OP_START, 64'd100);
		send_event(rsw_pkg::OP_END, 64'd1100);
		send_event(rsw_pkg::OP_START, 64'hFFFF_FFFF_FFFF_FFF0);
		send_event(rsw_pkg::OP_END, 64'h10);
		// time going backwards gives an all-ones sample, sum wraps
		send_event(rsw_pkg::OP_START, 64'd1000);
		send_event(rsw_pkg::OP_END, 64'd999);
		send_event(rsw_pkg::OP_START, '0);
		send_event(rsw_pkg::OP_END, ALL_ONES);
		send_event(rsw_pkg::OP_NOP, ALL_ONES);
		send_event(rsw_pkg::OP_START, 64'd5);
		send_event(rsw_pkg::OP_CLEAR, 64'd7);
		send_event(rsw_pkg::OP_END, 64'd9);
		send_event(rsw_pkg::OP_CLEAR, '0);
		send_event(rsw_pkg::OP_CLEAR, ALL_ONES);
		send_event(rsw_pkg::OP_END, 64'd3);
		send_event(rsw_pkg::OP_START, 64'h5555_5555_5555_5555);
		send_event(rsw_pkg::OP_END, 64'hAAAA_AAAA_AAAA_AAAA);
		send_event(rsw_pkg::OP_NOP, 64'h5555_5555_5555_5555);
		drain();

		wall = rand64();
		next_drain = items_sent + 250;
		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= next_drain) begin
				drain();
				next_drain += 250;
				quiet_phase = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < 78) begin
				if (board.running) begin
					send_event(rsw_pkg::OP_END, rand64());
				end
				stamp = $urandom_range(0, 1) ? rand64() : wall;
				send_event(rsw_pkg::OP_START, stamp);
				send_event(rsw_pkg::OP_END, stamp + pick_length());
				wall = stamp + DATA_W'($urandom_range(1, 100000));
			end else if (r < 86) begin
				send_event(rsw_pkg::OP_CLEAR, rand64());
			end else if (r < 93) begin
				send_event(rsw_pkg::OP_NOP, rand64());
			end else if (board.running) begin
				send_event(rsw_pkg::OP_START, rand64());
			end else begin
				send_event(rsw_pkg::OP_END, rand64());
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d items: %0d start, %0d end, %0d clear, %0d no-op, %0d out of order",
			items_sent, board.op_seen[rsw_pkg::OP_START], board.op_seen[rsw_pkg::OP_END],
			board.op_seen[rsw_pkg::OP_CLEAR], board.op_seen[rsw_pkg::OP_NOP],
			board.misordered_seen);
		$display("%0d results checked, %0d samples added, %0d mismatches",
			board.checked, board.samples_added, board.mismatches);
		if (board.mismatches == 0) begin
			$display("running_stats_welford_unit_test: PASS");
		end else begin
			$display("running_stats_welford_unit_test: FAIL");
		end
		$finish;
	end

endmodule

@@ running_stats_welford_unit.f @@
hw/rtl/rsw_pkg.sv
hw/rtl/running_stats_welford_unit.sv
hw/rtl/rsw_checker.sv
sim/running_stats_welford_unit_test.sv
